>>> hw/rtl/prg_pkg.sv
// ----------------------------------------------------------------------------
// prg_pkg
// Shared widths, control struct and saturation helper for the pairwise
// regression gradient block.
// ----------------------------------------------------------------------------
package prg_pkg;

  localparam int DATA_W           = 16;
  localparam int IDX_W            = 4;
  localparam int CFG_W            = 5;
  localparam int CNT_W            = 6;
  localparam int PAIR_W           = 7;
  localparam int PROD_W           = 2 * DATA_W;
  localparam int QUOT_W           = PROD_W - 8;
  localparam int SAT_W            = QUOT_W + 2;
  localparam int IN_TDATA_W       = 56;
  localparam int OUT_TDATA_W      = 56;
  localparam int DEF_MAX_ELEMENTS = 16;
  localparam logic [CFG_W-1:0] LEN_RESET = CFG_W'(16);

  typedef struct packed {
    logic ld_item;
    logic mul_x;
    logic ld_r;
    logic mul_r;
  } dp_ctl_t;

  function automatic logic signed [DATA_W-1:0] sat16(input logic signed [SAT_W-1:0] v);
    logic signed [DATA_W-1:0] res;
    if (v > SAT_W'(32767)) begin
      res = 16'sh7fff;
    end else if (v < -SAT_W'(32768)) begin
      res = 16'sh8000;
    end else begin
      res = v[DATA_W-1:0];
    end
    return res;
  endfunction

endpackage

>>> hw/rtl/pairwise_regression_gradient.sv
// ----------------------------------------------------------------------------
// pairwise_regression_gradient
// Loads a sample vector, then walks its upper-triangle pairs and emits the
// residual, slope gradient and offset gradient per pair in signed Q8.8.
// ----------------------------------------------------------------------------
// load beat: written to the store, no result
// pair beat: reads x and y, residual, then r*x; one shared multiplier used twice
// pair beats: no new beat is taken until the result enters the output register
// reset: walk at pair (0,1), pair count 0, vector_length 16, store undefined
// ----------------------------------------------------------------------------
module pairwise_regression_gradient
  import prg_pkg::*;
#(
  parameter int MAX_ELEMENTS = DEF_MAX_ELEMENTS
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // element_index, sample_value, model_slope, model_offset
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // action
  input  logic                   in_tuser,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // residual, slope_gradient, offset_gradient, pair_number
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic                   out_tlast,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_W-1:0]       cfg_data
);

  localparam int AW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;

  logic                     in_accept;
  logic                     wr_en;
  logic [AW-1:0]            wr_addr;
  logic [AW-1:0]            rd_addr;
  logic [DATA_W-1:0]        rd_data;
  dp_ctl_t                  ctl;
  logic                     fire;
  logic [PAIR_W-1:0]        pair_number;
  logic                     last_pair;
  logic signed [DATA_W-1:0] residual;
  logic signed [DATA_W-1:0] slope_gradient;
  logic signed [DATA_W-1:0] offset_gradient;

  logic                     out_valid_r;
  logic [OUT_TDATA_W-1:0]   out_data_r;
  logic                     out_last_r;

  assign in_accept = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  prg_seq #(
    .MAX_ELEMENTS(MAX_ELEMENTS)
  ) u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_accept   (in_accept),
    .in_action   (in_tuser),
    .in_index    (in_tdata[3:0]),
    .cfg_accept  (cfg_valid),
    .cfg_data    (cfg_data),
    .out_free    (!out_valid_r || out_tready),
    .in_ready    (in_tready),
    .wr_en       (wr_en),
    .wr_addr     (wr_addr),
    .rd_addr     (rd_addr),
    .ctl         (ctl),
    .fire        (fire),
    .pair_number (pair_number),
    .last_pair   (last_pair)
  );

  prg_ram #(
    .WIDTH(DATA_W),
    .DEPTH(MAX_ELEMENTS)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (in_tdata[19:4]),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  prg_dp u_dp (
    .clk             (clk),
    .ctl             (ctl),
    .model_slope     (in_tdata[35:20]),
    .model_offset    (in_tdata[51:36]),
    .rd_data         (rd_data),
    .residual        (residual),
    .slope_gradient  (slope_gradient),
    .offset_gradient (offset_gradient)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_data_r <= {1'b0, pair_number, offset_gradient, slope_gradient, residual};
      out_last_r <= last_pair;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule

>>> hw/rtl/prg_ram.sv
// ----------------------------------------------------------------------------
// prg_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module prg_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

>>> hw/rtl/prg_dp.sv
// ----------------------------------------------------------------------------
// prg_dp
// Datapath with one shared signed multiplier: forms the residual, then the
// slope and offset gradients, all saturated to 16 bits.
// ----------------------------------------------------------------------------
module prg_dp
  import prg_pkg::*;
(
  input  logic                     clk,
  input  dp_ctl_t                  ctl,
  input  logic signed [DATA_W-1:0] model_slope,
  input  logic signed [DATA_W-1:0] model_offset,
  input  logic signed [DATA_W-1:0] rd_data,
  output logic signed [DATA_W-1:0] residual,
  output logic signed [DATA_W-1:0] slope_gradient,
  output logic signed [DATA_W-1:0] offset_gradient
);

  logic signed [DATA_W-1:0] slope_r;
  logic signed [DATA_W-1:0] offset_r;
  logic signed [DATA_W-1:0] x_r;
  logic signed [DATA_W-1:0] r_r;
  logic signed [PROD_W-1:0] prod_r;

  logic signed [DATA_W-1:0] mul_a;
  logic signed [DATA_W-1:0] mul_b;
  logic signed [PROD_W-1:0] mul_p;
  logic signed [QUOT_W-1:0] quot;
  logic signed [SAT_W-1:0]  res_sum;
  logic signed [SAT_W-1:0]  sg_sum;
  logic signed [SAT_W-1:0]  og_sum;

  // shared multiplier: slope*x first, then r*x
  assign mul_a = ctl.mul_r ? r_r : slope_r;
  assign mul_b = ctl.mul_r ? x_r : rd_data;
  assign mul_p = mul_a * mul_b;

  // floor division by 256
  assign quot = prod_r[PROD_W-1:8];

  assign res_sum = {{2{quot[QUOT_W-1]}}, quot}
                 + {{(SAT_W-DATA_W){offset_r[DATA_W-1]}}, offset_r}
                 - {{(SAT_W-DATA_W){rd_data[DATA_W-1]}}, rd_data};
  assign sg_sum  = SAT_W'(0) - {quot[QUOT_W-1], quot, 1'b0};
  assign og_sum  = SAT_W'(0) - {{(SAT_W-DATA_W-1){r_r[DATA_W-1]}}, r_r, 1'b0};

  always_ff @(posedge clk) begin
    if (ctl.ld_item) begin
      slope_r  <= model_slope;
      offset_r <= model_offset;
    end
    if (ctl.mul_x) begin
      x_r <= rd_data;
    end
    if (ctl.mul_x || ctl.mul_r) begin
      prod_r <= mul_p;
    end
    if (ctl.ld_r) begin
      r_r <= sat16(res_sum);
    end
  end

  assign residual        = r_r;
  assign slope_gradient  = sat16(sg_sum);
  assign offset_gradient = sat16(og_sum);

endmodule

>>> hw/rtl/prg_seq.sv
// ----------------------------------------------------------------------------
// prg_seq
// Sequencer: length register, pair walk, store access and datapath steps.
// ----------------------------------------------------------------------------
module prg_seq
  import prg_pkg::*;
#(
  parameter int MAX_ELEMENTS = DEF_MAX_ELEMENTS,
  localparam int AW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_accept,
  input  logic              in_action,
  input  logic [IDX_W-1:0]  in_index,
  input  logic              cfg_accept,
  input  logic [CFG_W-1:0]  cfg_data,
  input  logic              out_free,
  output logic              in_ready,
  output logic              wr_en,
  output logic [AW-1:0]     wr_addr,
  output logic [AW-1:0]     rd_addr,
  output dp_ctl_t           ctl,
  output logic              fire,
  output logic [PAIR_W-1:0] pair_number,
  output logic              last_pair
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RDX  = 3'd1;
  localparam logic [2:0] S_RDY  = 3'd2;
  localparam logic [2:0] S_RES  = 3'd3;
  localparam logic [2:0] S_MUL  = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;

  localparam logic [CNT_W-1:0] N_MAX = CNT_W'(MAX_ELEMENTS);
  localparam logic [CNT_W-1:0] N_MIN = CNT_W'(2);

  logic [2:0]        state_r, state_nxt;
  logic [CFG_W-1:0]  len_r;
  logic [CNT_W-1:0]  n_r, n_nxt;
  logic [AW-1:0]     first_r, first_nxt;
  logic [AW-1:0]     second_r, second_nxt;
  logic [PAIR_W-1:0] cnt_r, cnt_nxt;

  logic [CNT_W-1:0]  n_clamp;
  logic [CNT_W-1:0]  first_w;
  logic [CNT_W-1:0]  second_w;
  logic [CNT_W-1:0]  sec_inc;
  logic              restart;

  assign first_w  = CNT_W'(first_r);
  assign second_w = CNT_W'(second_r);
  assign sec_inc  = second_w + CNT_W'(1);

  always_comb begin
    if (CNT_W'(len_r) < N_MIN) begin
      n_clamp = N_MIN;
    end else if (CNT_W'(len_r) > N_MAX) begin
      n_clamp = N_MAX;
    end else begin
      n_clamp = CNT_W'(len_r);
    end
  end

  assign restart   = !in_action || (second_w >= n_clamp) || (first_r >= second_r);
  assign last_pair = (first_w == n_r - CNT_W'(2)) && (second_w == n_r - CNT_W'(1));
  assign wr_en     = in_accept && !in_action && (CNT_W'(in_index) < N_MAX);
  assign wr_addr   = AW'(in_index);
  assign pair_number = cnt_r;
  assign in_ready  = (state_r == S_IDLE);

  always_comb begin
    state_nxt  = state_r;
    n_nxt      = n_r;
    first_nxt  = first_r;
    second_nxt = second_r;
    cnt_nxt    = cnt_r;
    rd_addr    = first_r;
    ctl        = '0;
    fire       = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          n_nxt = n_clamp;
          if (restart) begin
            first_nxt  = '0;
            second_nxt = AW'(1);
            cnt_nxt    = '0;
          end
          if (in_action) begin
            ctl.ld_item = 1'b1;
            state_nxt   = S_RDX;
          end
        end
      end
      S_RDX: begin
        state_nxt = S_RDY;
      end
      S_RDY: begin
        rd_addr   = second_r;
        ctl.mul_x = 1'b1;
        state_nxt = S_RES;
      end
      S_RES: begin
        ctl.ld_r  = 1'b1;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        ctl.mul_r = 1'b1;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (out_free) begin
          fire      = 1'b1;
          state_nxt = S_IDLE;
          if (last_pair) begin
            first_nxt  = '0;
            second_nxt = AW'(1);
            cnt_nxt    = '0;
          end else begin
            cnt_nxt = cnt_r + PAIR_W'(1);
            if (sec_inc >= n_r) begin
              first_nxt  = first_r + AW'(1);
              second_nxt = AW'(first_w + CNT_W'(2));
            end else begin
              second_nxt = AW'(sec_inc);
            end
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      len_r    <= LEN_RESET;
      n_r      <= N_MAX;
      first_r  <= '0;
      second_r <= AW'(1);
      cnt_r    <= '0;
    end else begin
      state_r  <= state_nxt;
      n_r      <= n_nxt;
      first_r  <= first_nxt;
      second_r <= second_nxt;
      cnt_r    <= cnt_nxt;
      if (cfg_accept) begin
        len_r <= cfg_data;
      end
    end
  end

endmodule
